FILE: hdl/rgbhsl_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// rgbhsl_pkg
// Shared widths and the per-stage payload of the RGB to HSL converter.
// ============================================================================
package rgbhsl_pkg;

    localparam int COMP_W     = 8;   // width of one color component
    localparam int FRAC_W     = 16;  // width of each HSL fraction
    localparam int NUM_CELLS  = 16;  // one quotient bit per division cell
    localparam int SAT_DEN_W  = 8;   // saturation divisor never exceeds 255
    localparam int HUE_DEN_W  = 11;  // six times delta never exceeds 1530

    // Everything one pixel carries from one division cell to the next.
    typedef struct packed {
        logic                 valid;
        logic [FRAC_W-1:0]    light;
        logic [SAT_DEN_W-1:0] sat_den;
        logic [SAT_DEN_W-1:0] sat_rem;
        logic [FRAC_W-1:0]    sat_num;
        logic [FRAC_W-1:0]    sat_q;
        logic [HUE_DEN_W-1:0] hue_den;
        logic [HUE_DEN_W-1:0] hue_rem;
        logic [FRAC_W-1:0]    hue_q;
    } t_div_state;

endpackage

FILE: hdl/rgbhsl_prep.sv
`timescale 1ns / 1ps
// ============================================================================
// rgbhsl_prep
// Front stage: extremes, lightness, and the numerators and divisors that the
// division cells work on.
// ============================================================================
module rgbhsl_prep
    import rgbhsl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_ce,
    input  logic              i_valid,
    input  logic [COMP_W-1:0] i_red,
    input  logic [COMP_W-1:0] i_green,
    input  logic [COMP_W-1:0] i_blue,
    output t_div_state        o_state
);

    logic [COMP_W-1:0]    w_max;
    logic [COMP_W-1:0]    w_min;
    logic [COMP_W-1:0]    w_dl;
    logic [COMP_W:0]      w_sum;
    logic [FRAC_W:0]      w_light_x2;
    logic [COMP_W:0]      w_den_hi;
    logic [23:0]          w_sat_num;
    logic [HUE_DEN_W-1:0] w_six;
    logic signed [12:0]   w_t;
    logic signed [12:0]   w_t_wrap;
    logic                 w_gray;
    t_div_state           r_state;
    t_div_state           n_state;

    always_comb begin
        w_max = i_red;
        if (i_green > w_max) w_max = i_green;
        if (i_blue > w_max) w_max = i_blue;
        w_min = i_red;
        if (i_green < w_min) w_min = i_green;
        if (i_blue < w_min) w_min = i_blue;

        w_dl       = w_max - w_min;
        w_gray     = (w_dl == '0);
        w_sum      = {1'b0, w_max} + {1'b0, w_min};
        w_light_x2 = {w_sum, 8'd0} + {8'd0, w_sum};
        w_den_hi   = 9'd510 - w_sum;
        w_sat_num  = {w_dl, 16'd0} - {16'd0, w_dl};
        w_six      = {1'b0, w_dl, 2'b00} + {2'b00, w_dl, 1'b0};

        // Red wins ties over green, green over blue.
        if (i_red == w_max) begin
            w_t = $signed({5'd0, i_green}) - $signed({5'd0, i_blue});
        end else if (i_green == w_max) begin
            w_t = $signed({4'd0, w_dl, 1'b0})
                + $signed({5'd0, i_blue}) - $signed({5'd0, i_red});
        end else begin
            w_t = $signed({3'd0, w_dl, 2'b00})
                + $signed({5'd0, i_red}) - $signed({5'd0, i_green});
        end
        w_t_wrap = (w_t < 0) ? (w_t + $signed({2'd0, w_six})) : w_t;

        n_state.valid   = i_valid;
        n_state.light   = w_light_x2[FRAC_W:1];
        // A gray pixel gets unit divisors so both quotients come out zero.
        if (w_gray) begin
            n_state.sat_den = SAT_DEN_W'(1);
            n_state.hue_den = HUE_DEN_W'(1);
        end else begin
            n_state.sat_den = (w_sum < 9'd255) ? w_sum[SAT_DEN_W-1:0]
                                               : w_den_hi[SAT_DEN_W-1:0];
            n_state.hue_den = w_six;
        end
        n_state.sat_rem = w_sat_num[23:16];
        n_state.sat_num = w_sat_num[15:0];
        n_state.sat_q   = '0;
        n_state.hue_rem = w_t_wrap[HUE_DEN_W-1:0];
        n_state.hue_q   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.valid <= 1'b0;
        end else if (i_ce) begin
            r_state.valid <= n_state.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_state.light   <= n_state.light;
            r_state.sat_den <= n_state.sat_den;
            r_state.sat_rem <= n_state.sat_rem;
            r_state.sat_num <= n_state.sat_num;
            r_state.sat_q   <= n_state.sat_q;
            r_state.hue_den <= n_state.hue_den;
            r_state.hue_rem <= n_state.hue_rem;
            r_state.hue_q   <= n_state.hue_q;
        end
    end

    assign o_state = r_state;

endmodule

FILE: hdl/rgbhsl_div_cell.sv
`timescale 1ns / 1ps
// ============================================================================
// rgbhsl_div_cell
// One restoring-division step for both saturation and hue, one quotient bit
// each, registered toward the next cell.
// ============================================================================
module rgbhsl_div_cell
    import rgbhsl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_ce,
    input  t_div_state i_prev,
    output t_div_state o_next
);

    logic [SAT_DEN_W:0]   w_sat_try;
    logic [SAT_DEN_W:0]   w_sat_diff;
    logic                 w_sat_bit;
    logic [HUE_DEN_W:0]   w_hue_try;
    logic [HUE_DEN_W:0]   w_hue_diff;
    logic                 w_hue_bit;
    t_div_state           r_state;
    t_div_state           n_state;

    always_comb begin
        w_sat_try  = {i_prev.sat_rem, i_prev.sat_num[FRAC_W-1]};
        w_sat_diff = w_sat_try - {1'b0, i_prev.sat_den};
        w_sat_bit  = (w_sat_try >= {1'b0, i_prev.sat_den});
        w_hue_try  = {i_prev.hue_rem, 1'b0};
        w_hue_diff = w_hue_try - {1'b0, i_prev.hue_den};
        w_hue_bit  = (w_hue_try >= {1'b0, i_prev.hue_den});

        n_state         = i_prev;
        n_state.sat_rem = w_sat_bit ? w_sat_diff[SAT_DEN_W-1:0]
                                    : w_sat_try[SAT_DEN_W-1:0];
        n_state.sat_num = {i_prev.sat_num[FRAC_W-2:0], 1'b0};
        n_state.sat_q   = {i_prev.sat_q[FRAC_W-2:0], w_sat_bit};
        n_state.hue_rem = w_hue_bit ? w_hue_diff[HUE_DEN_W-1:0]
                                    : w_hue_try[HUE_DEN_W-1:0];
        n_state.hue_q   = {i_prev.hue_q[FRAC_W-2:0], w_hue_bit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.valid <= 1'b0;
        end else if (i_ce) begin
            r_state.valid <= n_state.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_state.light   <= n_state.light;
            r_state.sat_den <= n_state.sat_den;
            r_state.sat_rem <= n_state.sat_rem;
            r_state.sat_num <= n_state.sat_num;
            r_state.sat_q   <= n_state.sat_q;
            r_state.hue_den <= n_state.hue_den;
            r_state.hue_rem <= n_state.hue_rem;
            r_state.hue_q   <= n_state.hue_q;
        end
    end

    assign o_next = r_state;

    // The partial remainders must stay below their divisors in every cell.
    a_sat_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.valid |-> (r_state.sat_rem < r_state.sat_den))
        else $error("saturation remainder not below divisor");

    a_hue_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.valid |-> (r_state.hue_rem < r_state.hue_den))
        else $error("hue remainder not below divisor");

    a_valid_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ce && i_prev.valid) |=> r_state.valid)
        else $error("valid request lost between cells");

endmodule

FILE: hdl/rgb_to_hsl_converter.sv
`timescale 1ns / 1ps
// ============================================================================
// rgb_to_hsl_converter
// Streams 8-bit RGB pixels in and 16-bit hue, saturation and lightness out.
// ============================================================================
//
//  Channel  Direction  Payload (low bit first)             Handshake
//  -------  ---------  ----------------------------------  -----------------
//  s        in         red[7:0] green[15:8] blue[23:16]    tvalid / tready
//  m        out        hue[15:0] sat[31:16] light[47:32]   tvalid / tready
//
// Each request passes through one front stage that finds max, min and the
// numerators, sixteen division cells that each produce one quotient bit of
// both divisions, and the output register. One request is taken per clock
// for as long as the output side keeps up. Reset (i_rst_n low at a clock
// edge) empties the chain. When the output stalls, the last finished
// request parks in a skid register and the whole chain freezes in the cycle
// after, so nothing is dropped.
//
module rgb_to_hsl_converter
    import rgbhsl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // red[7:0], green[15:8], blue[23:16]
    input  logic [3*COMP_W-1:0]   i_s_tdata,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // hue[15:0], saturation[31:16], lightness[47:32]
    output logic [3*FRAC_W-1:0]   o_m_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready
);

    t_div_state             w_chain [0:NUM_CELLS];
    t_div_state             w_last;
    logic                   w_ce;
    logic                   r_out_valid;
    logic [3*FRAC_W-1:0]    r_out_data;
    logic                   r_skid_valid;
    logic [3*FRAC_W-1:0]    r_skid_data;
    logic [3*FRAC_W-1:0]    w_last_data;

    // The chain advances whenever the skid register is free.
    assign w_ce       = !r_skid_valid;
    assign o_s_tready = w_ce;

    rgbhsl_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (i_s_tvalid),
        .i_red   (i_s_tdata[COMP_W-1:0]),
        .i_green (i_s_tdata[2*COMP_W-1:COMP_W]),
        .i_blue  (i_s_tdata[3*COMP_W-1:2*COMP_W]),
        .o_state (w_chain[0])
    );

    for (genvar g_cell = 0; g_cell < NUM_CELLS; g_cell++) begin : g_cells
        rgbhsl_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (w_ce),
            .i_prev  (w_chain[g_cell]),
            .o_next  (w_chain[g_cell+1])
        );
    end

    assign w_last      = w_chain[NUM_CELLS];
    assign w_last_data = {w_last.light, w_last.sat_q, w_last.hue_q};

    // Output register with a one-entry skid behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_m_tready) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (r_out_valid && !i_m_tready) begin
            r_skid_valid <= w_last.valid;
        end else begin
            r_out_valid <= w_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_m_tready) begin
                r_out_data <= r_skid_data;
            end
        end else if (r_out_valid && !i_m_tready) begin
            r_skid_data <= w_last_data;
        end else begin
            r_out_data <= w_last_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // A parked request always has a request in front of it.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds data with the output empty");

    a_skid_fill_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_m_tready))
        else $error("skid register filled without an output stall");

    // Zero saturation only happens for gray pixels, whose hue is zero too.
    a_gray_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data[2*FRAC_W-1:FRAC_W] == '0))
            |-> (r_out_data[FRAC_W-1:0] == '0))
        else $error("zero saturation with nonzero hue");

endmodule
